[design/wpi_pkg.sv]
// ----------------------------------------------------------------------------
// wpi_pkg: shared types and constants of the waypoint path interpolator
// item and result structs, register indexes, action codes, default sizes
// ----------------------------------------------------------------------------
package wpi_pkg;

	localparam int MAX_POINTS_DEF = 64;

	localparam int COORD_W = 16;
	localparam int TIME_W  = 15;
	localparam int SLOT_W  = 6;
	localparam int WPC_W   = 7;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT = 1'b1;

	// action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [SLOT_W-1:0]         point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [TIME_W-1:0]         path_time;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [TIME_W-1:0]         new_time;
	} out_item_t;

endpackage

[design/wpi_ram.sv]
// ----------------------------------------------------------------------------
// wpi_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module wpi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/wpi_div.sv]
// ----------------------------------------------------------------------------
// wpi_div: pipelined unsigned restoring divider
// one quotient bit per stage, sideband carried along
// ----------------------------------------------------------------------------
module wpi_div #(
	parameter int NUM_W  = 15,
	parameter int DEN_W  = 15,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              valid_out,
	output logic [NUM_W-1:0]  quo,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	logic              p_vld  [NUM_W+1];
	logic [NUM_W-1:0]  p_num  [NUM_W+1];
	logic [NUM_W-1:0]  p_quo  [NUM_W+1];
	logic [DEN_W-1:0]  p_rem  [NUM_W+1];
	logic [DEN_W-1:0]  p_den  [NUM_W+1];
	logic [SIDE_W-1:0] p_side [NUM_W+1];

	assign p_vld[0]  = valid_in;
	assign p_num[0]  = num;
	assign p_quo[0]  = '0;
	assign p_rem[0]  = '0;
	assign p_den[0]  = den;
	assign p_side[0] = side_in;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {p_rem[k], p_num[k][NUM_W-1]};
		assign diff  = trial - {1'b0, p_den[k]};
		assign ge    = trial >= {1'b0, p_den[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				p_vld[k+1] <= 1'b0;
			end else begin
				p_vld[k+1] <= p_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			p_num[k+1]  <= p_num[k] << 1;
			p_quo[k+1]  <= {p_quo[k][NUM_W-2:0], ge};
			p_rem[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			p_den[k+1]  <= p_den[k];
			p_side[k+1] <= p_side[k];
		end
	end

	assign valid_out = p_vld[NUM_W];
	assign quo       = p_quo[NUM_W];
	assign rem       = p_rem[NUM_W];
	assign side_out  = p_side[NUM_W];

endmodule

[design/waypoint_path_interpolator.sv]
// ----------------------------------------------------------------------------
// waypoint_path_interpolator: linear interpolation along a waypoint table
// throughput: one item per cycle, busy stays low; three bit-per-stage divider
//   pipelines (segment, major step, minor ratio) lie on the path to done
// reset: step_count and waypoint_count go to 1, pipeline valids clear,
//   waypoint memories keep their contents until written
// ----------------------------------------------------------------------------
module waypoint_path_interpolator #(
	parameter int MAX_POINTS = wpi_pkg::MAX_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           start,
	output logic                           busy,
	input  wpi_pkg::in_item_t              item,
	// result channel
	output logic                           done,
	output wpi_pkg::out_item_t             result,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpi_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int CW    = wpi_pkg::COORD_W;
	localparam int TW    = wpi_pkg::TIME_W;

	// sideband carried through the major-step divider
	typedef struct packed {
		logic [CW-1:0]        major;
		logic [CW-1:0]        minor;
		logic                 swap;
		logic                 dir_x;
		logic                 dir_y;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [TW-1:0]        new_time;
	} maj_side_t;

	// sideband carried through the minor-ratio divider
	typedef struct packed {
		logic                 swap;
		logic                 dir_x;
		logic                 dir_y;
		logic                 zero;
		logic                 t_neg;
		logic signed [CW-1:0] t;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [TW-1:0]        new_time;
	} min_side_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [TW-1:0]                 step_count_q;
	logic [wpi_pkg::WPC_W-1:0]     waypoint_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q     <= TW'(1);
			waypoint_count_q <= wpi_pkg::WPC_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wpi_pkg::CFG_STEP_COUNT:     step_count_q     <= cfg_data[TW-1:0];
				wpi_pkg::CFG_WAYPOINT_COUNT: waypoint_count_q <= cfg_data[wpi_pkg::WPC_W-1:0];
				default: ;
			endcase
		end
	end

	// zero step count acts as one, count clamps to the table size
	logic [TW-1:0]    steps;
	logic [CNT_W-1:0] count;

	assign steps = (step_count_q == '0) ? TW'(1) : step_count_q;
	assign count = (32'(waypoint_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
		: CNT_W'(waypoint_count_q);

	// ------------------------------------------------------------------
	// segment divider: time / steps, every item rides along so that
	// waypoint writes and reads stay in transfer order at the memories
	// ------------------------------------------------------------------
	logic                         acc;
	logic                         seg_vld;
	logic [TW-1:0]                seg_quo;
	logic [TW-1:0]                seg_rem;
	logic [$bits(wpi_pkg::in_item_t)-1:0] seg_side_raw;
	wpi_pkg::in_item_t            seg_item;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	wpi_div #(
		.NUM_W  (TW),
		.DEN_W  (TW),
		.SIDE_W ($bits(wpi_pkg::in_item_t))
	) u_seg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (acc),
		.num       (item.path_time),
		.den       (steps),
		.side_in   (item),
		.valid_out (seg_vld),
		.quo       (seg_quo),
		.rem       (seg_rem),
		.side_out  (seg_side_raw)
	);

	assign seg_item = wpi_pkg::in_item_t'(seg_side_raw);

	// past the last waypoint: restart at segment 0 with the remainder
	logic          wrapped;
	logic [AW-1:0] seg;
	logic [AW-1:0] nseg;
	logic [TW-1:0] norm_time;
	logic          wr_en;
	logic          query;

	assign wrapped   = 32'(seg_quo) >= 32'(count);
	assign seg       = wrapped ? '0 : AW'(seg_quo);
	assign nseg      = ((32'(seg) + 32'd1) < 32'(count)) ? AW'(32'(seg) + 32'd1) : '0;
	assign norm_time = wrapped ? seg_rem : seg_item.path_time;
	assign query     = seg_vld && (seg_item.action == wpi_pkg::ACT_QUERY);
	assign wr_en     = seg_vld && (seg_item.action == wpi_pkg::ACT_WRITE)
		&& (32'(seg_item.point_index) < MAX_POINTS);

	// ------------------------------------------------------------------
	// waypoint memories: one copy per read address
	// ------------------------------------------------------------------
	logic [CW-1:0] cx_rd, nx_rd, cy_rd, ny_rd;

	wpi_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_x_cur (
		.clk (clk), .we (wr_en), .waddr (AW'(seg_item.point_index)),
		.wdata (seg_item.point_x), .raddr (seg), .rdata (cx_rd)
	);
	wpi_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_x_nxt (
		.clk (clk), .we (wr_en), .waddr (AW'(seg_item.point_index)),
		.wdata (seg_item.point_x), .raddr (nseg), .rdata (nx_rd)
	);
	wpi_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_y_cur (
		.clk (clk), .we (wr_en), .waddr (AW'(seg_item.point_index)),
		.wdata (seg_item.point_y), .raddr (seg), .rdata (cy_rd)
	);
	wpi_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_y_nxt (
		.clk (clk), .we (wr_en), .waddr (AW'(seg_item.point_index)),
		.wdata (seg_item.point_y), .raddr (nseg), .rdata (ny_rd)
	);

	// stage 1: memory read in flight
	logic          vld_s1;
	logic [TW-1:0] step_s1;
	logic [TW-1:0] time_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= query;
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= seg_rem;
		time_s1 <= norm_time;
	end

	// ------------------------------------------------------------------
	// stage 2: extents per axis, pick the major axis
	// ------------------------------------------------------------------
	logic signed [CW:0] cx_e, nx_e, cy_e, ny_e;
	logic [CW-1:0]      dx, dy;
	logic               dir_x, dir_y, swap;

	assign cx_e  = {cx_rd[CW-1], cx_rd};
	assign nx_e  = {nx_rd[CW-1], nx_rd};
	assign cy_e  = {cy_rd[CW-1], cy_rd};
	assign ny_e  = {ny_rd[CW-1], ny_rd};
	assign dir_x = nx_e < cx_e;
	assign dir_y = ny_e < cy_e;
	assign dx    = dir_x ? CW'(cx_e - nx_e) : CW'(nx_e - cx_e);
	assign dy    = dir_y ? CW'(cy_e - ny_e) : CW'(ny_e - cy_e);
	assign swap  = dx < dy;

	logic      vld_s2;
	logic [TW-1:0] step_s2;
	maj_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		step_s2           <= step_s1;
		side_s2.major     <= swap ? dy : dx;
		side_s2.minor     <= swap ? dx : dy;
		side_s2.swap      <= swap;
		side_s2.dir_x     <= dir_x;
		side_s2.dir_y     <= dir_y;
		side_s2.cx        <= cx_rd;
		side_s2.cy        <= cy_rd;
		side_s2.new_time  <= time_s1;
	end

	// stage 3: major extent times step
	logic              vld_s3;
	logic [CW+TW-1:0]  prod_s3;
	maj_side_t         side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= (CW+TW)'(side_s2.major) * (CW+TW)'(step_s2);
		side_s3 <= side_s2;
	end

	// ------------------------------------------------------------------
	// major step divider: major * step / steps
	// ------------------------------------------------------------------
	logic                  maj_vld;
	logic [CW+TW-1:0]      maj_quo;
	logic [TW-1:0]         maj_rem;
	logic [$bits(maj_side_t)-1:0] maj_side_raw;
	maj_side_t             maj_side;

	wpi_div #(
		.NUM_W  (CW + TW),
		.DEN_W  (TW),
		.SIDE_W ($bits(maj_side_t))
	) u_maj_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vld_s3),
		.num       (prod_s3),
		.den       (steps),
		.side_in   (side_s3),
		.valid_out (maj_vld),
		.quo       (maj_quo),
		.rem       (maj_rem),
		.side_out  (maj_side_raw)
	);

	assign maj_side = maj_side_t'(maj_side_raw);

	// stage 4: wrap the major advance, take its magnitude
	logic signed [CW-1:0] t_w;

	assign t_w = maj_quo[CW-1:0];

	logic        vld_s4;
	logic [CW:0] abs_t_s4;
	logic [CW-1:0] minor_s4;
	logic [CW-1:0] major_s4;
	min_side_t   side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= maj_vld;
		end
	end

	always_ff @(posedge clk) begin
		abs_t_s4         <= t_w[CW-1] ? ((CW+1)'(0) - {t_w[CW-1], t_w}) : {1'b0, t_w};
		minor_s4         <= maj_side.minor;
		major_s4         <= maj_side.major;
		side_s4.swap     <= maj_side.swap;
		side_s4.dir_x    <= maj_side.dir_x;
		side_s4.dir_y    <= maj_side.dir_y;
		side_s4.zero     <= maj_side.major == '0;
		side_s4.t_neg    <= t_w[CW-1];
		side_s4.t        <= t_w;
		side_s4.cx       <= maj_side.cx;
		side_s4.cy       <= maj_side.cy;
		side_s4.new_time <= maj_side.new_time;
	end

	// stage 5: |t| times minor extent, fits in 32 bits
	logic          vld_s5;
	logic [31:0]   prod_s5;
	logic [CW-1:0] major_s5;
	min_side_t     side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s5  <= 32'(abs_t_s4) * 32'(minor_s4);
		major_s5 <= major_s4;
		side_s5  <= side_s4;
	end

	// ------------------------------------------------------------------
	// minor ratio divider: |t| * minor / major, sign restored after
	// a zero major extent gives garbage here and is overridden below
	// ------------------------------------------------------------------
	logic                  min_vld;
	logic [31:0]           min_quo;
	logic [CW-1:0]         min_rem;
	logic [$bits(min_side_t)-1:0] min_side_raw;
	min_side_t             min_side;

	wpi_div #(
		.NUM_W  (32),
		.DEN_W  (CW),
		.SIDE_W ($bits(min_side_t))
	) u_min_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vld_s5),
		.num       (prod_s5),
		.den       (major_s5),
		.side_in   (side_s5),
		.valid_out (min_vld),
		.quo       (min_quo),
		.rem       (min_rem),
		.side_out  (min_side_raw)
	);

	assign min_side = min_side_t'(min_side_raw);

	// ------------------------------------------------------------------
	// output stage: move each axis toward the next waypoint
	// ------------------------------------------------------------------
	logic signed [CW-1:0] amt_min;
	logic signed [CW-1:0] amt_x, amt_y;
	logic signed [CW-1:0] px, py;

	assign amt_min = min_side.t_neg ? (CW'(0) - min_quo[CW-1:0]) : min_quo[CW-1:0];
	assign amt_x   = min_side.swap ? amt_min : min_side.t;
	assign amt_y   = min_side.swap ? min_side.t : amt_min;

	always_comb begin
		if (min_side.zero) begin
			px = min_side.cx;
			py = min_side.cy;
		end else begin
			px = min_side.dir_x ? (min_side.cx - amt_x) : (min_side.cx + amt_x);
			py = min_side.dir_y ? (min_side.cy - amt_y) : (min_side.cy + amt_y);
		end
	end

	logic                done_q;
	wpi_pkg::out_item_t  result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= min_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.pos_x    <= px;
		result_q.pos_y    <= py;
		result_q.new_time <= min_side.new_time;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
